// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion violated");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_SYNC(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/ttco_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-tone crossfade oscillator package
// Widths, Q16 constants, controller states and datapath command types.
// ----------------------------------------------------------------------------
package ttco_pkg;

    localparam int PHASE_W  = 19;
    localparam int WEIGHT_W = 17;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [PHASE_W-1:0] Q16_PI        = 19'd205887;
    localparam logic [PHASE_W-1:0] Q16_FULL_TURN = 19'd411774;
    localparam logic [PHASE_W-1:0] STEP_A_RESET  = 19'd3705;
    localparam logic [PHASE_W-1:0] STEP_B_RESET  = 19'd7309;

    localparam logic signed [17:0] Q16_ONE   = 18'sd65536;
    // ceil(2^25 / 6) and ceil(2^32 / 120): exact quotients over the value ranges
    localparam logic signed [31:0] RECIP6    = 32'sd5592406;
    localparam logic signed [31:0] RECIP120  = 32'sd35791395;
    localparam logic signed [31:0] PCM_SCALE = 32'sd32767;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_B = 8'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ, S_SQ_W,
        S_CUBE, S_CUBE_W,
        S_FIFTH, S_FIFTH_W,
        S_DIV6, S_DIV6_W,
        S_DIV120, S_DIV120_W,
        S_LOAD_B,
        S_MIX_B, S_MIX_B_W,
        S_MIX_A, S_MIX_A_W,
        S_SCALE, S_SCALE_W
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SQ,
        MUL_CUBE,
        MUL_FIFTH,
        MUL_DIV6,
        MUL_DIV120,
        MUL_MIX_B,
        MUL_MIX_A,
        MUL_SCALE
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_NONE,
        ST_X_A,
        ST_X_B,
        ST_X2,
        ST_X3,
        ST_X5,
        ST_Q3,
        ST_WAVE_A,
        ST_WAVE_B,
        ST_MIX_B,
        ST_MIX_A,
        ST_OUT
    } store_sel_t;

    typedef struct packed {
        mul_sel_t   mul_sel;
        store_sel_t store_sel;
    } ctrl_cmd_t;

endpackage

// ===== rtl/ttco_ctrl.sv =====
// ----------------------------------------------------------------------------
// Oscillator controller
// Sequences the shared multiplier through both Taylor sines, the crossfade
// and the output scaling; owns the stream handshakes.
// ----------------------------------------------------------------------------
module ttco_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ttco_pkg::ctrl_cmd_t cmd
);

    ttco_pkg::state_t state_reg, state_next;
    logic             tone_b_reg, tone_b_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ttco_pkg::S_IDLE;
            tone_b_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tone_b_reg   <= tone_b_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        tone_b_next   = tone_b_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.mul_sel   = ttco_pkg::MUL_NONE;
        cmd.store_sel = ttco_pkg::ST_NONE;
        case (state_reg)
            ttco_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.store_sel = ttco_pkg::ST_X_A;
                    tone_b_next   = 1'b0;
                    state_next    = ttco_pkg::S_SQ;
                end
            end
            ttco_pkg::S_SQ: begin
                cmd.mul_sel = ttco_pkg::MUL_SQ;
                state_next  = ttco_pkg::S_SQ_W;
            end
            ttco_pkg::S_SQ_W: begin
                cmd.store_sel = ttco_pkg::ST_X2;
                state_next    = ttco_pkg::S_CUBE;
            end
            ttco_pkg::S_CUBE: begin
                cmd.mul_sel = ttco_pkg::MUL_CUBE;
                state_next  = ttco_pkg::S_CUBE_W;
            end
            ttco_pkg::S_CUBE_W: begin
                cmd.store_sel = ttco_pkg::ST_X3;
                state_next    = ttco_pkg::S_FIFTH;
            end
            ttco_pkg::S_FIFTH: begin
                cmd.mul_sel = ttco_pkg::MUL_FIFTH;
                state_next  = ttco_pkg::S_FIFTH_W;
            end
            ttco_pkg::S_FIFTH_W: begin
                cmd.store_sel = ttco_pkg::ST_X5;
                state_next    = ttco_pkg::S_DIV6;
            end
            ttco_pkg::S_DIV6: begin
                cmd.mul_sel = ttco_pkg::MUL_DIV6;
                state_next  = ttco_pkg::S_DIV6_W;
            end
            ttco_pkg::S_DIV6_W: begin
                cmd.store_sel = ttco_pkg::ST_Q3;
                state_next    = ttco_pkg::S_DIV120;
            end
            ttco_pkg::S_DIV120: begin
                cmd.mul_sel = ttco_pkg::MUL_DIV120;
                state_next  = ttco_pkg::S_DIV120_W;
            end
            ttco_pkg::S_DIV120_W: begin
                // finish the sine of the current tone, then go to tone B or the mix
                if (tone_b_reg) begin
                    cmd.store_sel = ttco_pkg::ST_WAVE_B;
                    state_next    = ttco_pkg::S_MIX_B;
                end else begin
                    cmd.store_sel = ttco_pkg::ST_WAVE_A;
                    state_next    = ttco_pkg::S_LOAD_B;
                end
            end
            ttco_pkg::S_LOAD_B: begin
                cmd.store_sel = ttco_pkg::ST_X_B;
                tone_b_next   = 1'b1;
                state_next    = ttco_pkg::S_SQ;
            end
            ttco_pkg::S_MIX_B: begin
                cmd.mul_sel = ttco_pkg::MUL_MIX_B;
                state_next  = ttco_pkg::S_MIX_B_W;
            end
            ttco_pkg::S_MIX_B_W: begin
                cmd.store_sel = ttco_pkg::ST_MIX_B;
                state_next    = ttco_pkg::S_MIX_A;
            end
            ttco_pkg::S_MIX_A: begin
                cmd.mul_sel = ttco_pkg::MUL_MIX_A;
                state_next  = ttco_pkg::S_MIX_A_W;
            end
            ttco_pkg::S_MIX_A_W: begin
                cmd.store_sel = ttco_pkg::ST_MIX_A;
                state_next    = ttco_pkg::S_SCALE;
            end
            ttco_pkg::S_SCALE: begin
                cmd.mul_sel = ttco_pkg::MUL_SCALE;
                state_next  = ttco_pkg::S_SCALE_W;
            end
            ttco_pkg::S_SCALE_W: begin
                // hold the product until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.store_sel = ttco_pkg::ST_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ttco_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ttco_pkg::S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ttco_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/ttco_datapath.sv =====
// ----------------------------------------------------------------------------
// Oscillator datapath
// Step and phase registers, one shared 32x32 multiplier with a product
// register, and the working registers of the sine and crossfade.
// ----------------------------------------------------------------------------
module ttco_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ttco_pkg::ctrl_cmd_t                   cmd,
    input  logic                                  cfg_wr,
    input  logic [ttco_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ttco_pkg::PHASE_W-1:0]          cfg_data,
    input  logic [ttco_pkg::WEIGHT_W-1:0]         in_weight,
    output logic signed [ttco_pkg::SAMPLE_W-1:0]  out_sample
);

    // Fold a phase in [0, 2pi] to [-pi, pi].
    function automatic logic signed [18:0] fold_phase(input logic [18:0] p);
        logic signed [19:0] d;
        begin
            if (p > ttco_pkg::Q16_PI) begin
                d = $signed({1'b0, p}) - $signed({1'b0, ttco_pkg::Q16_FULL_TURN});
            end else begin
                d = $signed({1'b0, p});
            end
            return d[18:0];
        end
    endfunction

    // Advance by a clamped step and wrap once by 2pi.
    function automatic logic [18:0] advance_phase(input logic [18:0] p,
                                                  input logic [18:0] step);
        logic [18:0] s;
        logic [19:0] sum;
        begin
            s   = (step > ttco_pkg::Q16_FULL_TURN) ? ttco_pkg::Q16_FULL_TURN : step;
            sum = {1'b0, p} + {1'b0, s};
            if (sum > {1'b0, ttco_pkg::Q16_FULL_TURN}) begin
                sum = sum - {1'b0, ttco_pkg::Q16_FULL_TURN};
            end
            return sum[18:0];
        end
    endfunction

    logic [18:0]        step_a_reg, step_a_next;
    logic [18:0]        step_b_reg, step_b_next;
    logic [18:0]        phase_a_reg, phase_a_next;
    logic [18:0]        phase_b_reg, phase_b_next;
    logic [16:0]        weight_reg, weight_next;
    logic signed [18:0] x_reg, x_next;
    logic signed [20:0] x2_reg, x2_next;
    logic signed [21:0] x3_reg, x3_next;
    logic signed [25:0] x5_reg, x5_next;
    logic signed [19:0] q3_reg, q3_next;
    logic signed [23:0] wave_a_reg, wave_a_next;
    logic signed [23:0] wave_b_reg, wave_b_next;
    logic signed [27:0] mix_reg, mix_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [15:0] sample_reg, sample_next;

    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod_asr;
    logic signed [21:0] x3_abs;
    logic signed [25:0] x5_abs;
    logic signed [17:0] one_minus_w;
    logic [18:0]        q3_mag, q5_mag;
    logic signed [19:0] q5_val;
    logic signed [26:0] wave_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_a_reg  <= ttco_pkg::STEP_A_RESET;
            step_b_reg  <= ttco_pkg::STEP_B_RESET;
            phase_a_reg <= '0;
            phase_b_reg <= '0;
        end else begin
            step_a_reg  <= step_a_next;
            step_b_reg  <= step_b_next;
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        weight_reg <= weight_next;
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        x3_reg     <= x3_next;
        x5_reg     <= x5_next;
        q3_reg     <= q3_next;
        wave_a_reg <= wave_a_next;
        wave_b_reg <= wave_b_next;
        mix_reg    <= mix_next;
        prod_reg   <= prod_next;
        sample_reg <= sample_next;
    end

    assign x3_abs      = x3_reg[21] ? -x3_reg : x3_reg;
    assign x5_abs      = x5_reg[25] ? -x5_reg : x5_reg;
    assign one_minus_w = ttco_pkg::Q16_ONE - $signed({1'b0, weight_reg});
    assign prod_asr    = prod_reg >>> 16;

    // Quotient magnitudes sit above the reciprocal's binary point.
    assign q3_mag   = prod_reg[43:25];
    assign q5_mag   = prod_reg[50:32];
    assign q5_val   = x5_reg[25] ? -$signed({1'b0, q5_mag}) : $signed({1'b0, q5_mag});
    assign wave_sum = 27'(x_reg) - 27'(q3_reg) + 27'(q5_val);

    // Operand select for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            ttco_pkg::MUL_SQ: begin
                op_a = 32'(x_reg);
                op_b = 32'(x_reg);
            end
            ttco_pkg::MUL_CUBE: begin
                op_a = 32'(x2_reg);
                op_b = 32'(x_reg);
            end
            ttco_pkg::MUL_FIFTH: begin
                op_a = 32'(x3_reg);
                op_b = 32'(x2_reg);
            end
            ttco_pkg::MUL_DIV6: begin
                op_a = {11'd0, x3_abs[20:0]};
                op_b = ttco_pkg::RECIP6;
            end
            ttco_pkg::MUL_DIV120: begin
                op_a = {7'd0, x5_abs[24:0]};
                op_b = ttco_pkg::RECIP120;
            end
            ttco_pkg::MUL_MIX_B: begin
                op_a = 32'(wave_b_reg);
                op_b = {15'd0, weight_reg};
            end
            ttco_pkg::MUL_MIX_A: begin
                op_a = 32'(wave_a_reg);
                op_b = 32'(one_minus_w);
            end
            ttco_pkg::MUL_SCALE: begin
                op_a = 32'(mix_reg);
                op_b = ttco_pkg::PCM_SCALE;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        step_a_next  = step_a_reg;
        step_b_next  = step_b_reg;
        phase_a_next = phase_a_reg;
        phase_b_next = phase_b_reg;
        weight_next  = weight_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        x3_next      = x3_reg;
        x5_next      = x5_reg;
        q3_next      = q3_reg;
        wave_a_next  = wave_a_reg;
        wave_b_next  = wave_b_reg;
        mix_next     = mix_reg;
        sample_next  = sample_reg;
        prod_next    = (cmd.mul_sel == ttco_pkg::MUL_NONE) ? prod_reg : op_a * op_b;

        if (cfg_wr) begin
            case (cfg_index)
                ttco_pkg::CFG_STEP_A: step_a_next = cfg_data;
                ttco_pkg::CFG_STEP_B: step_b_next = cfg_data;
                default: ;
            endcase
        end

        case (cmd.store_sel)
            ttco_pkg::ST_X_A: begin
                x_next      = fold_phase(phase_a_reg);
                weight_next = in_weight;
            end
            ttco_pkg::ST_X_B: begin
                x_next = fold_phase(phase_b_reg);
            end
            ttco_pkg::ST_X2: x2_next = prod_asr[20:0];
            ttco_pkg::ST_X3: x3_next = prod_asr[21:0];
            ttco_pkg::ST_X5: x5_next = prod_asr[25:0];
            ttco_pkg::ST_Q3: begin
                q3_next = x3_reg[21] ? -$signed({1'b0, q3_mag}) : $signed({1'b0, q3_mag});
            end
            ttco_pkg::ST_WAVE_A: wave_a_next = wave_sum[23:0];
            ttco_pkg::ST_WAVE_B: wave_b_next = wave_sum[23:0];
            ttco_pkg::ST_MIX_B:  mix_next    = prod_asr[27:0];
            ttco_pkg::ST_MIX_A:  mix_next    = mix_reg + prod_asr[27:0];
            ttco_pkg::ST_OUT: begin
                // saturate the scaled mix, then step both phases
                if (prod_asr > 64'sd32767) begin
                    sample_next = 16'sh7FFF;
                end else if (prod_asr < -64'sd32768) begin
                    sample_next = 16'sh8000;
                end else begin
                    sample_next = prod_asr[15:0];
                end
                phase_a_next = advance_phase(phase_a_reg, step_a_reg);
                phase_b_next = advance_phase(phase_b_reg, step_b_reg);
            end
            default: ;
        endcase
    end

    assign out_sample = sample_reg;

endmodule

// ===== rtl/two_tone_crossfade_oscillator_core.sv =====
// Two-tone crossfade oscillator. Each accepted transaction carries a Q16 weight
// and yields one stereo frame: two Q16 phase accumulators feed a fifth-order
// Taylor sine, the tones are crossfaded, scaled to 16 bits with saturation and
// sent identically on left and right. The result is computed by thirteen
// multiplications on one shared 32x32 multiplier, each an issue state and a
// write-back state, plus one state to load the second phase. A transaction is
// accepted only in the idle state, so none is taken while the current one
// is in work. The input is taken again as soon as the result sits in the
// output register; if that register is still held, the last step waits for
// it. Step registers are written through the configuration channel, which is
// always ready.
// ----------------------------------------------------------------------------
// Two-tone crossfade oscillator core
// Top level: stream ports, configuration channel, controller and datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_tone_crossfade_oscillator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [18:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] mix_weight, [23:17] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] left_sample, [31:16] right_sample
);

    ttco_pkg::ctrl_cmd_t cmd;
    logic signed [15:0]  sample;

    assign cfg_ready = 1'b1;

    ttco_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ttco_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_weight  (s_tdata[16:0]),
        .out_sample (sample)
    );

    assign m_tdata = {sample, sample};

    `ASSERT_SYNC(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    `ASSERT_NEVER(a_no_result_overwrite, aclk, aresetn, (cmd.store_sel == ttco_pkg::ST_OUT) && m_tvalid && !m_tready)
    `ASSERT_SYNC(a_square_before_x2, aclk, aresetn, (cmd.store_sel == ttco_pkg::ST_X2) |-> ($past(cmd.mul_sel) == ttco_pkg::MUL_SQ))

endmodule
